// ===== hdl/fscd_pkg.sv =====
// ----------------------------------------------------------------------------
// fscd_pkg
// Shared widths, codes and control types of the slot cache directory.
// ----------------------------------------------------------------------------
package fscd_pkg;

  localparam int OBJ_W       = 10;
  localparam int NUM_OBJECTS = 1 << OBJ_W;
  localparam int SLOT_W      = 6;
  localparam int NUM_SLOTS   = 1 << SLOT_W;
  localparam int OLIM_W      = 11;
  localparam int SLIM_W      = 7;
  localparam int DLY_W       = 32;
  localparam int ACT_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [ACT_W-1:0] ACT_GET   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LIMIT   = 2'd1;

  localparam logic [OLIM_W-1:0] OBJECT_LIMIT_RST = OLIM_W'(NUM_OBJECTS);
  localparam logic [SLIM_W-1:0] SLOT_LIMIT_RST   = SLIM_W'(NUM_SLOTS);

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_LOOK  = 4'b0100,
    ST_CHECK = 4'b1000
  } state_t;

  typedef struct packed {
    logic init_wr;    // zero the object map entry at the init address
    logic capture;    // latch item, read object map
    logic read_slot;  // read owner and delay at the mapped slot
    logic commit;     // update maps, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic init_last;  // init address sits on the last object map entry
    logic out_free;   // result register can take a new beat
  } dp_status_t;

endpackage

// ===== hdl/fscd_item_if.sv =====
// ----------------------------------------------------------------------------
// fscd_item_if
// Request channel: action, object id and delay.
// ----------------------------------------------------------------------------
interface fscd_item_if;
  logic                              valid;
  logic                              ready;
  logic [fscd_pkg::ACT_W-1:0]        action;
  logic [fscd_pkg::OBJ_W-1:0]        object_id;
  logic signed [fscd_pkg::DLY_W-1:0] delay_value;

  modport source (output valid, action, object_id, delay_value, input ready);
  modport sink   (input valid, action, object_id, delay_value, output ready);
endinterface

// ===== hdl/fscd_result_if.sv =====
// ----------------------------------------------------------------------------
// fscd_result_if
// Response channel: hit flag, slot and stored delay.
// ----------------------------------------------------------------------------
interface fscd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [fscd_pkg::SLOT_W-1:0]       slot;
  logic signed [fscd_pkg::DLY_W-1:0] delay_out;

  modport source (output valid, found, slot, delay_out, input ready);
  modport sink   (input valid, found, slot, delay_out, output ready);
endinterface

// ===== hdl/fscd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// fscd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fscd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fscd_pkg::CFG_IDX_W-1:0]   index;
  logic [fscd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/fifo_slot_cache_directory.sv =====
// ----------------------------------------------------------------------------
// fifo_slot_cache_directory
// Directory of an object cache with round-robin slot replacement.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel: get looks an object up, put places it
// (keeping its slot if resident, else taking the slot the round-robin pointer
// names and evicting its former owner) and stores its delay, clear drops
// every mapping. Each request yields one result beat: found, slot and delay.
// The cfg channel writes object_limit (index 0) and slot_limit (index 1);
// it is always ready and is meant to be written only while no request is
// in flight.
// One request is worked at a time, through object map read, then owner/delay
// read, then the map update and result load into the result register; a new
// request is taken only after the last one has committed.
// A stalled receiver holds the result in its output register; the next
// request is still taken and waits before commit until that beat leaves.
// Reset clears the slot valid bits, the round-robin pointer and restores
// the limit registers, then a pass zeroes all 1024 object map entries; no
// request is taken until that pass ends.
// ----------------------------------------------------------------------------
module fifo_slot_cache_directory (
  input  logic          clk,
  input  logic          rst,
  fscd_item_if.sink     item,
  fscd_result_if.source result,
  fscd_cfg_if.sink      cfg
);

  fscd_pkg::ctrl_cmd_t  cmd;
  fscd_pkg::dp_status_t status;

  assign cfg.ready = 1'b1;

  fscd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_ready (item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  fscd_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .action      (item.action),
    .object_id   (item.object_id),
    .delay_value (item.delay_value),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .out_ready   (result.ready),
    .out_valid   (result.valid),
    .found       (result.found),
    .slot        (result.slot),
    .delay_out   (result.delay_out)
  );

endmodule

// ===== hdl/fscd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fscd_ctrl
// Sequencer: accept a request, walk it through lookup and commit.
// ----------------------------------------------------------------------------
module fscd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fscd_pkg::dp_status_t   status,
  output fscd_pkg::ctrl_cmd_t    cmd
);

  fscd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fscd_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state)
      fscd_pkg::ST_INIT: begin
        // sweep the object map once before taking requests
        cmd.init_wr = 1'b1;
        if (status.init_last) begin
          state_next = fscd_pkg::ST_IDLE;
        end
      end
      fscd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = fscd_pkg::ST_LOOK;
        end
      end
      fscd_pkg::ST_LOOK: begin
        cmd.read_slot = 1'b1;
        state_next    = fscd_pkg::ST_CHECK;
      end
      fscd_pkg::ST_CHECK: begin
        // hold until the result register frees up
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = fscd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fscd_pkg::ST_INIT;
      end
    endcase
  end

endmodule

// ===== hdl/fscd_datapath.sv =====
// ----------------------------------------------------------------------------
// fscd_datapath
// Object map, slot owner and delay memories, limit registers, round-robin
// pointer and result register.
// ----------------------------------------------------------------------------
module fscd_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  fscd_pkg::ctrl_cmd_t                 cmd,
  output fscd_pkg::dp_status_t                status,
  input  logic [fscd_pkg::ACT_W-1:0]          action,
  input  logic [fscd_pkg::OBJ_W-1:0]          object_id,
  input  logic signed [fscd_pkg::DLY_W-1:0]   delay_value,
  input  logic                                cfg_we,
  input  logic [fscd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fscd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                found,
  output logic [fscd_pkg::SLOT_W-1:0]         slot,
  output logic signed [fscd_pkg::DLY_W-1:0]   delay_out
);

  // Object residency is derived: an object is resident when the slot its map
  // entry names is valid and owned by it. Reusing a slot thus unmaps the
  // former owner, and a clear only drops the slot valid bits.
  logic [fscd_pkg::SLOT_W-1:0] obj_map   [fscd_pkg::NUM_OBJECTS];
  logic [fscd_pkg::OBJ_W-1:0]  owner_map [fscd_pkg::NUM_SLOTS];
  logic [fscd_pkg::DLY_W-1:0]  delay_mem [fscd_pkg::NUM_SLOTS];
  logic [fscd_pkg::NUM_SLOTS-1:0] owner_valid;

  logic [fscd_pkg::OLIM_W-1:0] object_limit;
  logic [fscd_pkg::SLIM_W-1:0] slot_limit;
  logic [fscd_pkg::SLOT_W-1:0] next_slot, next_slot_next;
  logic [fscd_pkg::OBJ_W-1:0]  init_addr;

  logic [fscd_pkg::ACT_W-1:0]        act_r;
  logic [fscd_pkg::OBJ_W-1:0]        id_r;
  logic signed [fscd_pkg::DLY_W-1:0] dly_r;
  logic [fscd_pkg::SLOT_W-1:0]       map_q;
  logic [fscd_pkg::SLOT_W-1:0]       slot_q;
  logic [fscd_pkg::OBJ_W-1:0]        own_q;
  logic [fscd_pkg::DLY_W-1:0]        dly_q;

  logic                              in_range, hit, do_put, do_clear, alloc_we;
  logic [fscd_pkg::SLIM_W-1:0]       lim, alloc_inc;
  logic [fscd_pkg::SLOT_W-1:0]       alloc_slot, put_slot;
  logic                              found_next;
  logic [fscd_pkg::SLOT_W-1:0]       slot_next;
  logic signed [fscd_pkg::DLY_W-1:0] delay_next;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= action;
      id_r  <= object_id;
      dly_r <= delay_value;
    end
  end

  // init sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      init_addr <= '0;
    end else if (cmd.init_wr) begin
      init_addr <= init_addr + fscd_pkg::OBJ_W'(1);
    end
  end

  // object map: read on capture, write on allocation or init sweep
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      map_q <= obj_map[object_id];
    end
    if (alloc_we) begin
      obj_map[id_r] <= alloc_slot;
    end else if (cmd.init_wr) begin
      obj_map[init_addr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_slot) begin
      own_q  <= owner_map[map_q];
      slot_q <= map_q;
    end
    if (alloc_we) begin
      owner_map[alloc_slot] <= id_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_slot) begin
      dly_q <= delay_mem[map_q];
    end
    if (do_put) begin
      delay_mem[put_slot] <= dly_r;
    end
  end

  always_comb begin
    in_range = fscd_pkg::OLIM_W'(id_r) < object_limit;
    hit      = in_range && owner_valid[slot_q] && (own_q == id_r);
    do_put   = cmd.commit && (act_r == fscd_pkg::ACT_PUT) && in_range;
    do_clear = cmd.commit && (act_r == fscd_pkg::ACT_CLEAR);
    alloc_we = do_put && !hit;

    priority if (slot_limit == '0) begin
      lim = fscd_pkg::SLIM_W'(1);
    end else if (slot_limit > fscd_pkg::SLIM_W'(fscd_pkg::NUM_SLOTS)) begin
      lim = fscd_pkg::SLIM_W'(fscd_pkg::NUM_SLOTS);
    end else begin
      lim = slot_limit;
    end

    // a pointer at or beyond a lowered limit restarts at slot zero
    alloc_slot     = (fscd_pkg::SLIM_W'(next_slot) < lim) ? next_slot : '0;
    alloc_inc      = fscd_pkg::SLIM_W'(alloc_slot) + fscd_pkg::SLIM_W'(1);
    next_slot_next = (alloc_inc >= lim) ? '0 : alloc_inc[fscd_pkg::SLOT_W-1:0];
    put_slot       = hit ? slot_q : alloc_slot;

    found_next = 1'b0;
    slot_next  = '0;
    delay_next = '0;
    unique case (act_r)
      fscd_pkg::ACT_GET: begin
        if (hit) begin
          found_next = 1'b1;
          slot_next  = slot_q;
          delay_next = dly_q;
        end
      end
      fscd_pkg::ACT_PUT: begin
        if (in_range) begin
          found_next = 1'b1;
          slot_next  = put_slot;
          delay_next = dly_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owner_valid <= '0;
      next_slot   <= '0;
    end else if (do_clear) begin
      owner_valid <= '0;
    end else if (alloc_we) begin
      owner_valid[alloc_slot] <= 1'b1;
      next_slot               <= next_slot_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_limit <= fscd_pkg::OBJECT_LIMIT_RST;
      slot_limit   <= fscd_pkg::SLOT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fscd_pkg::REG_OBJECT_LIMIT: object_limit <= cfg_data[fscd_pkg::OLIM_W-1:0];
        fscd_pkg::REG_SLOT_LIMIT:   slot_limit   <= cfg_data[fscd_pkg::SLIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found     <= found_next;
      slot      <= slot_next;
      delay_out <= delay_next;
    end
  end

  always_comb begin
    status.out_free  = !out_valid || out_ready;
    status.init_last = (init_addr == '1);
  end

endmodule

// ===== hdl/fscd_checker.sv =====
// ----------------------------------------------------------------------------
// fscd_checker
// Port-level checks of the slot cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module fscd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                item_valid,
  input logic                                item_ready,
  input logic                                result_valid,
  input logic                                result_ready,
  input logic                                found,
  input logic [fscd_pkg::SLOT_W-1:0]         slot,
  input logic signed [fscd_pkg::DLY_W-1:0]   delay_out
);

  // a result beat is held until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(found) &&
      $stable(slot) && $stable(delay_out))
    else $error("result beat dropped or changed while stalled");

  // a miss reports zero slot and zero delay
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !found |-> slot == '0 && delay_out == '0)
    else $error("miss carries nonzero slot or delay");

  // one request in flight: no new beat taken right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("request taken while another is in flight");

  // no result can appear sooner than the lookup pipeline allows
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !result_valid |=> !result_valid ##1 !result_valid)
    else $error("result appeared before lookup finished");

endmodule

bind fifo_slot_cache_directory fscd_checker u_fscd_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .found        (result.found),
  .slot         (result.slot),
  .delay_out    (result.delay_out)
);
